// ----- rtl/scrp_pkg.sv -----
package scrp_pkg;

  // Longest ticker the record may declare (1 to 10)
  localparam logic [7:0] TICKER_LIMIT = 8'd10;

  // Reset value of the required fee decimals register
  localparam logic [7:0] FEE_DEC_RESET = 8'd18;

  // Chain id length in bytes
  localparam logic [3:0] CHAIN_BYTES = 4'd8;

  // Result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Ticker selectors
  localparam logic TICKER_ASSET = 1'b0;
  localparam logic TICKER_FEE   = 1'b1;

  // Summary status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_ASSET_LEN  = 3'd1,
    ST_ASSET_TRUNC    = 3'd2,
    ST_CHAIN_TRUNC    = 3'd3,
    ST_BAD_FEE_LEN    = 3'd4,
    ST_FEE_TRUNC      = 3'd5,
    ST_WRONG_FEE_DEC  = 3'd6
  } status_t;

endpackage

// ----- rtl/swap_config_record_parser_top.sv -----
// Swap configuration record parser.
// Input channel (in_valid/in_stall): one record byte per item, data_byte plus
// last_byte marking the final byte of the record. An item is taken at a clock
// edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): at most one result per input byte.
// Ticker characters come out as character results (kind 0); the last byte of
// a record always yields one summary (kind 1) with status, decimals, chain id,
// ticker lengths and fee presence. Other bytes yield nothing.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes required_fee_decimals;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low; the parse state
// updates in the cycle the byte is taken. A result is loaded into the output
// register at the clock edge that accepts its byte.
// When the receiver stalls with a result pending, in_stall rises until the
// output register is taken; the result holds steady meanwhile.
// Reset (rst, synchronous, active high): parser expects an asset length byte,
// the output register is empty, required_fee_decimals returns to 18.
module swap_config_record_parser_top import scrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        which_ticker,
  output logic [3:0]  char_index,
  output logic [7:0]  ticker_char,
  output logic [2:0]  status,
  output logic [7:0]  asset_dec_places,
  output logic [7:0]  fee_decimals,
  output logic [63:0] network_id,
  output logic [3:0]  asset_sym_len,
  output logic [3:0]  fee_ticker_len,
  output logic        fee_present
);

  typedef enum logic [2:0] {
    PH_ASSET_LEN,
    PH_ASSET_CHR,
    PH_ASSET_DEC,
    PH_CHAIN,
    PH_FEE_LEN,
    PH_FEE_CHR,
    PH_FEE_DEC,
    PH_DONE
  } phase_t;

  logic [7:0]  required_fee_decimals;
  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] chain_value, chain_value_next;
  logic [7:0]  asset_dec_reg, asset_dec_reg_next;
  logic [7:0]  fee_dec_reg, fee_dec_reg_next;
  logic [3:0]  asset_len_reg, asset_len_reg_next;
  logic [3:0]  fee_len_reg, fee_len_reg_next;
  status_t     error_code, error_code_next;
  logic        fee_seen, fee_seen_next;

  logic        accept;
  logic        emit_char;
  logic        char_which;
  logic        len_ok;
  logic [3:0]  count_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign len_ok    = (data_byte != 8'd0) && (data_byte <= TICKER_LIMIT);
  assign count_inc = byte_count + 4'd1;

  // Advance the parse state for one record byte
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    chain_value_next   = chain_value;
    asset_dec_reg_next = asset_dec_reg;
    fee_dec_reg_next   = fee_dec_reg;
    asset_len_reg_next = asset_len_reg;
    fee_len_reg_next   = fee_len_reg;
    error_code_next    = error_code;
    fee_seen_next      = fee_seen;
    emit_char          = 1'b0;
    char_which         = TICKER_ASSET;
    if (error_code == ST_OK) begin
      case (phase)
        PH_ASSET_LEN: begin
          if (!len_ok) begin
            error_code_next = ST_BAD_ASSET_LEN;
          end else begin
            asset_len_reg_next = data_byte[3:0];
            byte_count_next    = 4'd0;
            phase_next         = PH_ASSET_CHR;
            if (last_byte) error_code_next = ST_ASSET_TRUNC;
          end
        end
        PH_ASSET_CHR: begin
          if (last_byte) begin
            error_code_next = ST_ASSET_TRUNC;
          end else begin
            emit_char       = 1'b1;
            char_which      = TICKER_ASSET;
            byte_count_next = count_inc;
            if (count_inc == asset_len_reg) phase_next = PH_ASSET_DEC;
          end
        end
        PH_ASSET_DEC: begin
          asset_dec_reg_next = data_byte;
          byte_count_next    = 4'd0;
          phase_next         = PH_CHAIN;
          if (last_byte) error_code_next = ST_CHAIN_TRUNC;
        end
        PH_CHAIN: begin
          chain_value_next = {chain_value[55:0], data_byte};
          byte_count_next  = count_inc;
          if (count_inc >= CHAIN_BYTES) begin
            phase_next = PH_FEE_LEN;
          end else if (last_byte) begin
            error_code_next = ST_CHAIN_TRUNC;
          end
        end
        PH_FEE_LEN: begin
          fee_seen_next = 1'b1;
          if (!len_ok) begin
            error_code_next = ST_BAD_FEE_LEN;
          end else begin
            fee_len_reg_next = data_byte[3:0];
            byte_count_next  = 4'd0;
            phase_next       = PH_FEE_CHR;
            if (last_byte) error_code_next = ST_FEE_TRUNC;
          end
        end
        PH_FEE_CHR: begin
          if (last_byte) begin
            error_code_next = ST_FEE_TRUNC;
          end else begin
            emit_char       = 1'b1;
            char_which      = TICKER_FEE;
            byte_count_next = count_inc;
            if (count_inc == fee_len_reg) phase_next = PH_FEE_DEC;
          end
        end
        PH_FEE_DEC: begin
          fee_dec_reg_next = data_byte;
          phase_next       = PH_DONE;
          if (data_byte != required_fee_decimals) error_code_next = ST_WRONG_FEE_DEC;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the config register
  always_ff @(posedge clk) begin
    if (rst) begin
      required_fee_decimals <= FEE_DEC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      required_fee_decimals <= cfg_data;
    end
  end

  // Update parse state; rearm after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ASSET_LEN;
      byte_count    <= 4'd0;
      chain_value   <= 64'd0;
      asset_dec_reg <= 8'd0;
      fee_dec_reg   <= FEE_DEC_RESET;
      asset_len_reg <= 4'd0;
      fee_len_reg   <= 4'd0;
      error_code    <= ST_OK;
      fee_seen      <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        phase         <= PH_ASSET_LEN;
        byte_count    <= 4'd0;
        chain_value   <= 64'd0;
        asset_dec_reg <= 8'd0;
        fee_dec_reg   <= required_fee_decimals;
        asset_len_reg <= 4'd0;
        fee_len_reg   <= 4'd0;
        error_code    <= ST_OK;
        fee_seen      <= 1'b0;
      end else begin
        phase         <= phase_next;
        byte_count    <= byte_count_next;
        chain_value   <= chain_value_next;
        asset_dec_reg <= asset_dec_reg_next;
        fee_dec_reg   <= fee_dec_reg_next;
        asset_len_reg <= asset_len_reg_next;
        fee_len_reg   <= fee_len_reg_next;
        error_code    <= error_code_next;
        fee_seen      <= fee_seen_next;
      end
    end
  end

  // Output register valid: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (last_byte || emit_char)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      kind             <= KIND_SUMMARY;
      which_ticker     <= TICKER_ASSET;
      char_index       <= 4'd0;
      ticker_char      <= 8'd0;
      status           <= error_code_next;
      asset_dec_places <= asset_dec_reg_next;
      fee_decimals     <= (phase_next == PH_DONE) ? fee_dec_reg_next : required_fee_decimals;
      network_id       <= chain_value_next;
      asset_sym_len    <= asset_len_reg_next;
      fee_ticker_len   <= fee_len_reg_next;
      fee_present      <= fee_seen_next;
    end else if (accept && emit_char) begin
      kind             <= KIND_CHAR;
      which_ticker     <= char_which;
      char_index       <= byte_count;
      ticker_char      <= data_byte;
      status           <= ST_OK;
      asset_dec_places <= 8'd0;
      fee_decimals     <= 8'd0;
      network_id       <= 64'd0;
      asset_sym_len    <= 4'd0;
      fee_ticker_len   <= 4'd0;
      fee_present      <= 1'b0;
    end
  end

endmodule
